// ===== hdl/json_syntax_validator_macros.svh =====
// Assertion macros used by the JSON syntax validator RTL.
`ifndef JSON_SYNTAX_VALIDATOR_MACROS_SVH
`define JSON_SYNTAX_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define JSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define JSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JSV_ASSERT(label, prop, msg)
`define JSV_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/jsv_pkg.sv =====
// Shared types and constants of the JSON syntax validator.
package jsv_pkg;

    localparam int MAX_NESTING_DEF   = 64;
    localparam int POSITION_BITS_DEF = 16;

    // Request operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SYNTAX = 2'd1,
        ERR_DEEP   = 2'd2,
        ERR_END    = 2'd3
    } err_kind_t;

    // Parser status seen by the top level
    typedef struct packed {
        err_kind_t err;
        logic      done;
    } jsv_status_t;

endpackage

// ===== hdl/jsv_if.sv =====
// Request and result channel interfaces of the JSON syntax validator.
interface jsv_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_req;

    modport source (output valid, output op, output byte_req, input ready);
    modport sink (input valid, input op, input byte_req, output ready);
endinterface

interface jsv_res_if
    import jsv_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     valid_res;
    logic [1:0]               error_kind;
    logic [POSITION_BITS-1:0] error_position;

    modport source (output valid, output valid_res, output error_kind,
                    output error_position, input ready);
    modport sink (input valid, input valid_res, input error_kind,
                  input error_position, output ready);
endinterface

// ===== hdl/json_syntax_validator.sv =====
// Timing: a request is registered in the input register on acceptance and parsed from there;
// the verdict of an end request is then registered in the result register.
// Throughput: one request per cycle; an end request waits only while an untaken verdict
// blocks the result register.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the parser
// to expecting the top-level container; an end request also restarts the parser.
`include "json_syntax_validator_macros.svh"

module json_syntax_validator
    import jsv_pkg::*;
#(
    parameter int MAX_NESTING   = MAX_NESTING_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    jsv_req_if.sink   req,
    jsv_res_if.source res
);

    // Input register: one request waiting to be parsed
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_ch_reg;

    // Result register: one verdict waiting to be taken
    logic                     res_valid_reg;
    logic                     res_ok_reg;
    err_kind_t                res_kind_reg;
    logic [POSITION_BITS-1:0] res_pos_reg;

    jsv_status_t              status;
    logic [POSITION_BITS-1:0] pos;

    logic advance;
    logic byte_step;
    logic end_step;
    logic doc_ok;

    // A byte request always advances; an end request needs room in the result register
    assign advance   = in_valid_reg &&
                       ((in_op_reg == OP_BYTE) || !res_valid_reg || res.ready);
    assign byte_step = advance && (in_op_reg == OP_BYTE);
    assign end_step  = advance && (in_op_reg == OP_END);
    assign req.ready = !in_valid_reg || advance;

    assign doc_ok = (status.err == ERR_NONE) && status.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (end_step)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg <= req.op;
            in_ch_reg <= req.byte_req;
        end
    end

    // Form the verdict: a latched error wins, then an unclosed document
    always_ff @(posedge clk)
    begin
        if (end_step)
        begin
            res_ok_reg <= doc_ok;
            if (status.err != ERR_NONE)
            begin
                res_kind_reg <= status.err;
                res_pos_reg  <= pos;
            end
            else if (status.done)
            begin
                res_kind_reg <= ERR_NONE;
                res_pos_reg  <= '0;
            end
            else
            begin
                res_kind_reg <= ERR_END;
                res_pos_reg  <= pos;
            end
        end
    end

    jsv_parser #(
        .MAX_NESTING   (MAX_NESTING),
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (byte_step),
        .clear  (end_step),
        .ch     (in_ch_reg),
        .status (status),
        .pos    (pos)
    );

    assign res.valid          = res_valid_reg;
    assign res.valid_res      = res_ok_reg;
    assign res.error_kind     = res_kind_reg;
    assign res.error_position = res_pos_reg;

    // A valid verdict carries no error kind and a zero position
    `JSV_ASSERT(a_valid_clean, !(res_valid_reg && res_ok_reg) || ((res_kind_reg == ERR_NONE) && (res_pos_reg == '0)), "valid verdict carries an error")

    // An end request restarts the parser with no error and no finished document
    `JSV_ASSERT_NEXT(a_end_restart, end_step, (status.err == ERR_NONE) && !status.done && (pos == '0), "parser not restarted after end request")

    // Once an error is latched the byte index holds while bytes keep arriving
    `JSV_ASSERT_NEXT(a_err_hold, byte_step && (status.err != ERR_NONE), $stable(pos) && (status.err == $past(status.err)), "error index moved after error")

    // Only an end request fills the result register
    `JSV_ASSERT_NEXT(a_res_source, !end_step && !res_valid_reg, !res_valid_reg, "result appeared without end request")

endmodule

// ===== hdl/jsv_stack.sv =====
// Shift-register container stack: bit 0 is the innermost container.
module jsv_stack #(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic push,
    input  logic pop,
    input  logic push_bit,
    output logic top
);

    logic [DEPTH-1:0] stack_reg;
    logic [DEPTH-1:0] stack_next;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic from_below;
        logic from_above;
        if (i == 0) begin : g_first
            assign from_below = push_bit;
        end
        else begin : g_rest
            assign from_below = stack_reg[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign from_above = stack_reg[i];
        end
        else begin : g_inner
            assign from_above = stack_reg[i+1];
        end
        assign stack_next[i] = push ? from_below : (pop ? from_above : stack_reg[i]);
    end

    // Entries are only read below the live depth, so no reset
    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

    assign top = stack_reg[0];

endmodule

// ===== hdl/jsv_parser.sv =====
// Per-byte JSON grammar state machine with error latch and byte counter.
module jsv_parser
    import jsv_pkg::*;
#(
    parameter int MAX_NESTING   = MAX_NESTING_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     clear,
    input  logic [7:0]               ch,
    output jsv_status_t              status,
    output logic [POSITION_BITS-1:0] pos
);

    localparam int DEPTH_BITS = $clog2(MAX_NESTING + 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [1:0] LW_TRUE  = 2'd0;
    localparam logic [1:0] LW_FALSE = 2'd1;
    localparam logic [1:0] LW_NULL  = 2'd2;

    typedef enum logic [4:0] {
        M_START, M_OBJ_FIRST, M_ARR_FIRST, M_KEY, M_COLON, M_VALUE,
        M_NEXT_KEY, M_AFTER, M_STRING, M_NUM_SIGN, M_NUM_INT, M_NUM_DOT,
        M_NUM_FRAC, M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL, M_DONE
    } mode_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] word, input logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        case ({word, k})
            {LW_TRUE, 3'd0}:  c = 8'h74; // t
            {LW_TRUE, 3'd1}:  c = 8'h72; // r
            {LW_TRUE, 3'd2}:  c = 8'h75; // u
            {LW_TRUE, 3'd3}:  c = 8'h65; // e
            {LW_FALSE, 3'd0}: c = 8'h66; // f
            {LW_FALSE, 3'd1}: c = 8'h61; // a
            {LW_FALSE, 3'd2}: c = 8'h6C; // l
            {LW_FALSE, 3'd3}: c = 8'h73; // s
            {LW_FALSE, 3'd4}: c = 8'h65; // e
            {LW_NULL, 3'd0}:  c = 8'h6E; // n
            {LW_NULL, 3'd1}:  c = 8'h75; // u
            {LW_NULL, 3'd2}:  c = 8'h6C; // l
            {LW_NULL, 3'd3}:  c = 8'h6C; // l
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [2:0]               lit_reg, lit_next;
    logic [DEPTH_BITS-1:0]    depth_reg, depth_next;
    err_kind_t                err_reg, err_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic       top_bit;
    logic       arr;
    logic       push;
    logic       pop;
    logic       push_bit;
    logic [1:0] word;
    logic [2:0] word_len;
    logic       live;

    assign live = step && (err_reg == ERR_NONE);
    assign arr  = (depth_reg != '0) && top_bit;

    always_comb
    begin
        word     = LW_TRUE;
        word_len = 3'd4;
        if (mode_reg == M_LIT_FALSE)
        begin
            word     = LW_FALSE;
            word_len = 3'd5;
        end
        else if (mode_reg == M_LIT_NULL)
        begin
            word = LW_NULL;
        end
    end

    always_comb
    begin
        logic syn;
        logic open_req;
        logic open_arr;
        logic close_req;
        logic vstart;
        logic after;
        mode_next  = mode_reg;
        lit_next   = lit_reg;
        syn        = 1'b0;
        open_req   = 1'b0;
        open_arr   = 1'b0;
        close_req  = 1'b0;
        vstart     = 1'b0;
        after      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        push_bit   = 1'b0;
        err_next   = err_reg;
        depth_next = depth_reg;

        case (mode_reg)
            M_START:
                if (!is_ws(ch))
                begin
                    if (ch == CH_LBRC) open_req = 1'b1;
                    else if (ch == CH_LBRK)
                    begin
                        open_req = 1'b1;
                        open_arr = 1'b1;
                    end
                    else syn = 1'b1;
                end
            M_OBJ_FIRST:
                if (!is_ws(ch))
                begin
                    if (ch == CH_RBRC) close_req = 1'b1;
                    else if (ch == CH_QUOTE) mode_next = M_KEY;
                    else syn = 1'b1;
                end
            M_ARR_FIRST:
                if (ch == CH_RBRK) close_req = 1'b1;
                else vstart = 1'b1;
            M_NEXT_KEY:
                if (!is_ws(ch))
                begin
                    if (ch == CH_QUOTE) mode_next = M_KEY;
                    else syn = 1'b1;
                end
            M_KEY:
                if (ch == 8'h00) syn = 1'b1;
                else if (ch == CH_QUOTE) mode_next = M_COLON;
            M_COLON:
                if (!is_ws(ch))
                begin
                    if (ch == CH_COLON) mode_next = M_VALUE;
                    else syn = 1'b1;
                end
            M_VALUE:
                vstart = 1'b1;
            M_AFTER:
                after = 1'b1;
            M_STRING:
                if (ch == 8'h00) syn = 1'b1;
                else if (ch == CH_QUOTE) mode_next = M_AFTER;
            M_NUM_SIGN:
                if (is_dig(ch)) mode_next = M_NUM_INT;
                else syn = 1'b1;
            M_NUM_INT:
                if (!is_dig(ch))
                begin
                    if (ch == CH_DOT) mode_next = M_NUM_DOT;
                    else after = 1'b1;
                end
            M_NUM_DOT:
                if (is_dig(ch)) mode_next = M_NUM_FRAC;
                else syn = 1'b1;
            M_NUM_FRAC:
                if (!is_dig(ch)) after = 1'b1;
            M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL:
                if ((lit_reg >= word_len) || (ch != lit_char(word, lit_reg))) syn = 1'b1;
                else if ((lit_reg + 3'd1) == word_len)
                begin
                    lit_next  = 3'd0;
                    mode_next = M_AFTER;
                end
                else lit_next = lit_reg + 3'd1;
            M_DONE:
                if (!is_ws(ch)) syn = 1'b1;
            default:
                syn = 1'b1;
        endcase

        if (vstart && !is_ws(ch))
        begin
            if (ch == CH_QUOTE) mode_next = M_STRING;
            else if (ch == CH_MINUS) mode_next = M_NUM_SIGN;
            else if (is_dig(ch)) mode_next = M_NUM_INT;
            else if (ch == CH_LBRC) open_req = 1'b1;
            else if (ch == CH_LBRK)
            begin
                open_req = 1'b1;
                open_arr = 1'b1;
            end
            else if (ch == CH_T)
            begin
                mode_next = M_LIT_TRUE;
                lit_next  = 3'd1;
            end
            else if (ch == CH_F)
            begin
                mode_next = M_LIT_FALSE;
                lit_next  = 3'd1;
            end
            else if (ch == CH_N)
            begin
                mode_next = M_LIT_NULL;
                lit_next  = 3'd1;
            end
            else syn = 1'b1;
        end

        if (after)
        begin
            mode_next = M_AFTER;
            if (!is_ws(ch))
            begin
                if (ch == CH_COMMA) mode_next = arr ? M_VALUE : M_NEXT_KEY;
                else if ((ch == CH_RBRC) && !arr) close_req = 1'b1;
                else if ((ch == CH_RBRK) && arr) close_req = 1'b1;
                else syn = 1'b1;
            end
        end

        if (open_req)
        begin
            if (depth_reg == DEPTH_BITS'(MAX_NESTING)) err_next = ERR_DEEP;
            else
            begin
                push       = live;
                push_bit   = open_arr;
                depth_next = depth_reg + 1'b1;
                mode_next  = open_arr ? M_ARR_FIRST : M_OBJ_FIRST;
            end
        end

        if (close_req)
        begin
            pop = live;
            if (depth_reg != '0) depth_next = depth_reg - 1'b1;
            mode_next = (depth_reg <= DEPTH_BITS'(1)) ? M_DONE : M_AFTER;
        end

        if (syn) err_next = ERR_SYNTAX;
    end

    // Count bytes until the first error, then hold its index
    always_comb
    begin
        pos_next = pos_reg;
        if ((err_next == ERR_NONE) && (pos_reg != '1)) pos_next = pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            lit_reg   <= 3'd0;
            depth_reg <= '0;
            err_reg   <= ERR_NONE;
            pos_reg   <= '0;
        end
        else if (clear)
        begin
            mode_reg  <= M_START;
            lit_reg   <= 3'd0;
            depth_reg <= '0;
            err_reg   <= ERR_NONE;
            pos_reg   <= '0;
        end
        else if (live)
        begin
            mode_reg  <= mode_next;
            lit_reg   <= lit_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            pos_reg   <= pos_next;
        end
    end

    jsv_stack #(
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .clk      (clk),
        .push     (push),
        .pop      (pop),
        .push_bit (push_bit),
        .top      (top_bit)
    );

    assign status.err  = err_reg;
    assign status.done = (mode_reg == M_DONE);
    assign pos         = pos_reg;

endmodule
